### hdl/bsc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsc_pkg: shared types and helpers for the base32 stream codec
// Job format between front and back, status codes, alphabet mapping.
// ---------------------------------------------------------------------------
package bsc_pkg;

	// Register indexes on the configuration port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_WS    = 1'b1;

	// Default depth of the job queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Symbol classes returned by the character classifier
	localparam logic [7:0] SYM_WS  = 8'h80;
	localparam logic [7:0] SYM_PAD = 8'h81;
	localparam logic [7:0] SYM_BAD = 8'hFF;

	localparam logic [7:0] CHAR_PAD = 8'h3D;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_CHAR  = 2'd1,
		ST_AFTER_PAD = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	// One unit of output work: a group of up to eight results
	typedef struct packed {
		mode_t       mode;
		logic [39:0] data;      // group, left aligned
		logic [2:0]  last_idx;  // number of results minus one
		logic [3:0]  sym_cnt;   // encode: data characters before the pads
		status_t     status;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} job_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Map a 5-bit symbol to its alphabet character
	function automatic logic [7:0] sym_to_char(input logic [4:0] v);
		if (v < 5'd26) begin
			return 8'd65 + {3'b000, v};
		end else begin
			return 8'd24 + {3'b000, v};
		end
	endfunction

	// Map a character to a symbol value or a class code
	function automatic logic [7:0] char_to_sym(input logic [7:0] c);
		if (c inside {[8'h41:8'h5A]}) begin
			return c - 8'h41;
		end else if (c inside {[8'h32:8'h37]}) begin
			return c - 8'd24;
		end else if (c == CHAR_PAD) begin
			return SYM_PAD;
		end else if (c inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
			return SYM_WS;
		end else begin
			return SYM_BAD;
		end
	endfunction

endpackage
`default_nettype wire

### hdl/base32_stream_codec.sv
`default_nettype none
// ---------------------------------------------------------------------------
// base32_stream_codec: streaming base32 encoder and decoder
// Front classifies words and builds groups, a job queue decouples it from
// the back, which sends out the results.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | in_byte, in_last
//  out     | out       | out_valid/out_ready  | out_byte, out_last, status
//
// The front takes one word per cycle while the job queue has a free slot.
// The back sends one result per cycle while the output is not stalled; encode
// puts out eight characters for each group of up to five bytes.
// Results leave through an output register loaded from the job that heads
// the queue. Reset clears registers and group state at once; no sweep.
// A stalled output holds the back; the front keeps going until the queue fills.
// ---------------------------------------------------------------------------
module base32_stream_codec #(
	parameter int QUEUE_DEPTH = bsc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                          cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          in_last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         out_byte,
	output logic                               out_last,
	output logic [1:0]                         status
);

	bsc_pkg::job_req_t      req;
	bsc_pkg::job_t          head;
	bsc_pkg::queue_status_t q_status;
	logic                   pop;
	bsc_pkg::status_t       st;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	bsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.q_status  (q_status),
		.req       (req)
	);

	bsc_job_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	bsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.status    (st)
	);

	assign status = st;

endmodule
`default_nettype wire

### hdl/bsc_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsc_front: input side of the base32 stream codec
// Accepts words, keeps the group state and the registers, and issues at most
// one job per finished group or error.
// ---------------------------------------------------------------------------
module bsc_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                          cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          in_last,
	input  wire bsc_pkg::queue_status_t        q_status,
	output bsc_pkg::job_req_t                  req
);

	bsc_pkg::mode_t dir_q;
	logic           skip_ws_q;
	logic [39:0]    group_q;
	logic [3:0]     fill_q;
	logic [3:0]     pad_q;
	logic           pad_seen_q;

	logic [39:0] g_nx;
	logic [3:0]  f_nx;
	logic [3:0]  p_nx;
	logic        ps_nx;

	logic        take;
	logic        dir_wr;
	logic [7:0]  sym;
	logic        is_ws;
	logic        skip;
	bsc_pkg::status_t err;
	logic [39:0] g_acc;
	logic [3:0]  f_acc;
	logic [3:0]  p_acc;
	logic        ps_acc;
	logic [4:0]  v;
	logic [39:0] g_emit;
	logic [3:0]  p_tot;
	logic [5:0]  shamt;
	logic [2:0]  drop;
	logic [2:0]  cnt;
	logic [3:0]  nsym;

	// Stall input only when no job slot is left
	assign in_ready = !q_status.full;
	assign take     = in_valid && in_ready;
	assign dir_wr   = cfg_valid && (cfg_index == bsc_pkg::REG_DIRECTION);

	// Classify the word and work out the next group state
	always_comb begin
		g_nx    = group_q;
		f_nx    = fill_q;
		p_nx    = pad_q;
		ps_nx   = pad_seen_q;
		req     = '0;
		sym     = bsc_pkg::char_to_sym(in_byte);
		is_ws   = (sym == bsc_pkg::SYM_WS);
		skip    = is_ws && skip_ws_q;
		err     = bsc_pkg::ST_OK;
		g_acc   = group_q;
		f_acc   = fill_q;
		p_acc   = pad_q;
		ps_acc  = pad_seen_q;
		v       = sym[4:0];
		g_emit  = '0;
		p_tot   = '0;
		shamt   = '0;
		drop    = '0;
		cnt     = '0;
		nsym    = 4'd8;
		if (dir_q == bsc_pkg::MODE_ENC) begin
			// Encode: gather bytes, issue a group at five or at the end
			g_acc = {group_q[31:0], in_byte};
			f_acc = fill_q + 4'd1;
			case (f_acc)
				4'd1: begin
					g_emit = g_acc << 32;
					nsym   = 4'd2;
				end
				4'd2: begin
					g_emit = g_acc << 24;
					nsym   = 4'd4;
				end
				4'd3: begin
					g_emit = g_acc << 16;
					nsym   = 4'd5;
				end
				4'd4: begin
					g_emit = g_acc << 8;
					nsym   = 4'd7;
				end
				default: begin
					g_emit = g_acc;
					nsym   = 4'd8;
				end
			endcase
			if (f_acc == 4'd5 || in_last) begin
				req.push         = 1'b1;
				req.job.mode     = bsc_pkg::MODE_ENC;
				req.job.data     = g_emit;
				req.job.last_idx = 3'd7;
				req.job.sym_cnt  = nsym;
				req.job.status   = bsc_pkg::ST_OK;
				g_nx = '0;
				f_nx = '0;
				p_nx = '0;
			end else begin
				g_nx = g_acc;
				f_nx = f_acc;
			end
			if (in_last) begin
				ps_nx = 1'b0;
			end
		end else begin
			// Decode: check the character first
			if (!skip) begin
				if (sym == bsc_pkg::SYM_BAD || is_ws) begin
					err = bsc_pkg::ST_BAD_CHAR;
				end else if (sym != bsc_pkg::SYM_PAD && pad_seen_q) begin
					err = bsc_pkg::ST_AFTER_PAD;
				end
			end
			// Append the symbol, a pad counts as zero bits
			if (!skip && err == bsc_pkg::ST_OK) begin
				if (sym == bsc_pkg::SYM_PAD) begin
					p_acc  = pad_q + 4'd1;
					ps_acc = 1'b1;
					v      = 5'd0;
				end
				g_acc = {group_q[34:0], v};
				f_acc = fill_q + 4'd1;
			end
			// Zero-fill a short group and count the missing symbols as pads
			if (f_acc == 4'd8) begin
				g_emit = g_acc;
				p_tot  = p_acc;
			end else begin
				shamt  = 6'(5 * (4'd8 - f_acc));
				g_emit = g_acc << shamt;
				p_tot  = p_acc + (4'd8 - f_acc);
			end
			drop = (p_tot == 4'd0) ? 3'd0 : 3'(p_tot >> 1) + 3'd1;
			cnt  = (drop >= 3'd5) ? 3'd0 : 3'd5 - drop;
			if (err != bsc_pkg::ST_OK) begin
				req.push         = 1'b1;
				req.job.mode     = bsc_pkg::MODE_DEC;
				req.job.data     = '0;
				req.job.last_idx = 3'd0;
				req.job.sym_cnt  = '0;
				req.job.status   = err;
				if (in_last) begin
					g_nx  = '0;
					f_nx  = '0;
					p_nx  = '0;
					ps_nx = 1'b0;
				end
			end else begin
				if ((f_acc == 4'd8 || (in_last && f_acc != 4'd0)) && cnt != 3'd0) begin
					req.push         = 1'b1;
					req.job.mode     = bsc_pkg::MODE_DEC;
					req.job.data     = g_emit;
					req.job.last_idx = cnt - 3'd1;
					req.job.sym_cnt  = '0;
					req.job.status   = bsc_pkg::ST_OK;
				end
				if (f_acc == 4'd8 || in_last) begin
					g_nx = '0;
					f_nx = '0;
					p_nx = '0;
				end else begin
					g_nx = g_acc;
					f_nx = f_acc;
					p_nx = p_acc;
				end
				ps_nx = in_last ? 1'b0 : ps_acc;
			end
		end
		req.push = req.push && take;
	end

	// Hold group state; a direction write clears the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q    <= '0;
			fill_q     <= '0;
			pad_q      <= '0;
			pad_seen_q <= 1'b0;
		end else if (dir_wr) begin
			group_q    <= '0;
			fill_q     <= '0;
			pad_q      <= '0;
			pad_seen_q <= 1'b0;
		end else if (take) begin
			group_q    <= g_nx;
			fill_q     <= f_nx;
			pad_q      <= p_nx;
			pad_seen_q <= ps_nx;
		end
	end

	// Hold the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q     <= bsc_pkg::MODE_ENC;
			skip_ws_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bsc_pkg::REG_DIRECTION: begin
					dir_q <= bsc_pkg::mode_t'(cfg_data);
				end
				bsc_pkg::REG_SKIP_WS: begin
					skip_ws_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/bsc_job_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsc_job_queue: short job queue between front and back
// Register-based FIFO; the head entry is visible without a read cycle.
// ---------------------------------------------------------------------------
module bsc_job_queue #(
	parameter int DEPTH = bsc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bsc_pkg::job_req_t      req,
	input  wire logic                   pop,
	output bsc_pkg::job_t               head,
	output bsc_pkg::queue_status_t      q_status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bsc_pkg::job_t      mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign q_status.full  = (cnt_q == CNT_W'(DEPTH));
	assign q_status.empty = (cnt_q == '0);
	assign do_push = req.push && !q_status.full;
	assign do_pop  = pop && !q_status.empty;
	assign head    = mem_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= req.job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/bsc_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsc_back: output side of the base32 stream codec
// Expands the head job into one result word per cycle, while the output is
// not stalled, into an output register.
// ---------------------------------------------------------------------------
module bsc_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bsc_pkg::job_t          head,
	input  wire bsc_pkg::queue_status_t q_status,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [7:0]                  out_byte,
	output logic                        out_last,
	output bsc_pkg::status_t            status
);

	logic [2:0]  k_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	bsc_pkg::status_t status_q;

	logic        adv;
	logic        is_last;
	logic [39:0] enc_sh;
	logic [39:0] dec_sh;
	logic [7:0]  res_byte;

	assign adv     = !q_status.empty && (!out_valid_q || out_ready);
	assign is_last = (k_q == head.last_idx);
	assign pop     = adv && is_last;

	// Select the next character or byte of the head job
	always_comb begin
		enc_sh = head.data << 6'(5 * k_q);
		dec_sh = head.data << 6'(8 * k_q);
		if (head.mode == bsc_pkg::MODE_ENC) begin
			if ({1'b0, k_q} < head.sym_cnt) begin
				res_byte = bsc_pkg::sym_to_char(enc_sh[39:35]);
			end else begin
				res_byte = bsc_pkg::CHAR_PAD;
			end
		end else begin
			res_byte = dec_sh[39:32];
		end
	end

	// Load the output register, step through the job, drop taken words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				k_q         <= is_last ? 3'd0 : k_q + 3'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= res_byte;
			out_last_q <= is_last;
			status_q   <= head.status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign status    = status_q;

endmodule
`default_nettype wire

### hdl/bsc_port_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsc_port_checker: port-level checks for the base32 stream codec
// Watches the output channel for stall behavior and error word form.
// ---------------------------------------------------------------------------
module bsc_port_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [7:0]                    out_byte,
	input wire logic                          out_last,
	input wire logic [1:0]                    status
);

	// A stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
			$stable(out_last) && $stable(status))
		else $error("output word changed while stalled");

	// An error word is a lone zero word that closes its batch
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> out_last && out_byte == 8'd0)
		else $error("error word with data or without last");

	// Status never carries the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("unused status code on output");

	// Encode output and decode output after a pad stay consistent: a pad
	// character never carries an error status
	a_pad_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == bsc_pkg::CHAR_PAD |-> status == 2'd0)
		else $error("pad character with error status");

endmodule

bind base32_stream_codec bsc_port_checker u_port_checker (.*);
`default_nettype wire
